/* hdl/nic_pkg.sv */
// ----------------------------------------------------------------------------
// nic_pkg
// Shared types, command codes and helpers for the nested interrupt controller.
// ----------------------------------------------------------------------------
package nic_pkg;

    localparam int unsigned LINE_W = 3;

    // Operation codes carried by each request
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_LINE  = 2'd2,
        OP_ACK   = 2'd3
    } op_t;

    // One-shot register-read selection
    typedef enum logic [1:0] {
        SEL_NONE = 2'd0,
        SEL_REQ  = 2'd1,
        SEL_SVC  = 2'd2
    } sel_t;

    // Command port bytes
    localparam logic [7:0] CMD_EOI_MASK = 8'hF8;
    localparam logic [7:0] CMD_EOI      = 8'h20;
    localparam logic [7:0] CMD_READ_IRR = 8'h0A;
    localparam logic [7:0] CMD_READ_ISR = 8'h0B;

    // Vector base handling
    localparam logic [7:0] BASE_MAX      = 8'd247;
    localparam logic [7:0] BASE_FALLBACK = 8'h08;
    localparam logic [7:0] BASE_ALIGN    = 8'hF8;
    localparam logic [7:0] BASE_RESET    = 8'h08;

    typedef struct packed {
        logic              found;
        logic [LINE_W-1:0] idx;
    } line_t;

    typedef struct packed {
        op_t               op;
        logic              port_select;
        logic [7:0]        write_data;
        logic [LINE_W-1:0] irq_line;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] vector;
        logic       vector_valid;
        logic       intr;
    } result_t;

    // Lowest set bit of a byte
    function automatic line_t lowest_set(input logic [7:0] v);
        line_t r;
        r = '0;
        for (int i = 7; i >= 0; i--) begin
            if (v[i]) begin
                r.found = 1'b1;
                r.idx   = LINE_W'(i);
            end
        end
        return r;
    endfunction

endpackage

/* hdl/nic_grant.sv */
// ----------------------------------------------------------------------------
// nic_grant
// Fully nested priority resolve: lowest unmasked request that outranks
// every in-service line.
// ----------------------------------------------------------------------------
module nic_grant #(
    parameter int unsigned LINES = 8
) (
    input  logic [7:0]     req,
    input  logic [7:0]     svc,
    input  logic [7:0]     mask,
    output nic_pkg::line_t grant
);

    localparam logic [7:0] LineMask = 8'((16'd1 << LINES) - 16'd1);

    nic_pkg::line_t cand;
    nic_pkg::line_t busy;

    assign cand = nic_pkg::lowest_set(req & ~mask & LineMask);
    assign busy = nic_pkg::lowest_set(svc & LineMask);

    always_comb begin
        grant       = cand;
        grant.found = cand.found && (!busy.found || (cand.idx < busy.idx));
    end

endmodule

/* hdl/nic_core.sv */
// ----------------------------------------------------------------------------
// nic_core
// Controller state and the single-pass update for one request.
// ----------------------------------------------------------------------------
module nic_core #(
    parameter int unsigned LINES = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  nic_pkg::item_t   item,
    input  logic [7:0]       vector_base,
    output nic_pkg::result_t result
);

    localparam logic [7:0] LineMask = 8'((16'd1 << LINES) - 16'd1);

    logic [7:0]    req_reg,  req_next;
    logic [7:0]    svc_reg,  svc_next;
    logic [7:0]    mask_reg, mask_next;
    logic          intr_reg, intr_next;
    logic          intr_keep;
    logic          raise;
    nic_pkg::sel_t sel_reg,  sel_next;

    nic_pkg::line_t grant_now;
    nic_pkg::line_t grant_after;
    nic_pkg::line_t svc_low;
    logic [7:0]     base_eff;
    logic [7:0]     rd;
    logic [7:0]     vec;
    logic           vec_valid;

    nic_grant #(.LINES(LINES)) u_grant_now (
        .req   (req_reg),
        .svc   (svc_reg),
        .mask  (mask_reg),
        .grant (grant_now)
    );

    nic_grant #(.LINES(LINES)) u_grant_after (
        .req   (req_next),
        .svc   (svc_next),
        .mask  (mask_next),
        .grant (grant_after)
    );

    assign svc_low  = nic_pkg::lowest_set(svc_reg & LineMask);
    assign base_eff = (vector_base > nic_pkg::BASE_MAX) ? nic_pkg::BASE_FALLBACK
                                                         : (vector_base & nic_pkg::BASE_ALIGN);

    always_comb begin
        req_next  = req_reg;
        svc_next  = svc_reg;
        mask_next = mask_reg;
        sel_next  = sel_reg;
        intr_keep = intr_reg;
        raise     = 1'b0;
        rd        = '0;
        vec       = '0;
        vec_valid = 1'b0;
        unique case (item.op)
            nic_pkg::OP_WRITE: begin
                if (item.port_select) begin
                    mask_next = item.write_data;
                    raise     = 1'b1;
                end else if ((item.write_data & nic_pkg::CMD_EOI_MASK) == nic_pkg::CMD_EOI) begin
                    // non-specific end of interrupt: drop the highest in-service line
                    if (svc_low.found) begin
                        svc_next = svc_reg & ~(8'd1 << svc_low.idx);
                    end
                    raise = 1'b1;
                end else if (item.write_data == nic_pkg::CMD_READ_IRR) begin
                    sel_next = nic_pkg::SEL_REQ;
                end else if (item.write_data == nic_pkg::CMD_READ_ISR) begin
                    sel_next = nic_pkg::SEL_SVC;
                end
            end
            nic_pkg::OP_READ: begin
                if (item.port_select) begin
                    rd = mask_reg;
                end else begin
                    unique case (sel_reg)
                        nic_pkg::SEL_REQ: begin
                            rd       = req_reg;
                            sel_next = nic_pkg::SEL_NONE;
                        end
                        nic_pkg::SEL_SVC: begin
                            rd       = svc_reg;
                            sel_next = nic_pkg::SEL_NONE;
                        end
                        default: begin
                            rd = '0;
                        end
                    endcase
                end
            end
            nic_pkg::OP_LINE: begin
                if ({1'b0, item.irq_line} < (nic_pkg::LINE_W + 1)'(LINES)) begin
                    req_next = req_reg | (8'd1 << item.irq_line);
                    raise    = 1'b1;
                end
            end
            nic_pkg::OP_ACK: begin
                intr_keep = 1'b0;
                if (grant_now.found) begin
                    req_next  = req_reg & ~(8'd1 << grant_now.idx);
                    svc_next  = svc_reg | (8'd1 << grant_now.idx);
                    vec       = base_eff + 8'(grant_now.idx);
                    vec_valid = 1'b1;
                end
            end
            default: begin
                intr_keep = intr_reg;
            end
        endcase
    end

    assign intr_next = intr_keep | (raise & grant_after.found);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_reg  <= '0;
            svc_reg  <= '0;
            mask_reg <= '0;
            intr_reg <= 1'b0;
            sel_reg  <= nic_pkg::SEL_NONE;
        end else if (advance) begin
            req_reg  <= req_next;
            svc_reg  <= svc_next;
            mask_reg <= mask_next;
            intr_reg <= intr_next;
            sel_reg  <= sel_next;
        end
    end

    always_comb begin
        result.read_data    = rd;
        result.vector       = vec;
        result.vector_valid = vec_valid;
        result.intr         = intr_next;
    end

endmodule

/* hdl/nested_interrupt_controller.sv */
// ----------------------------------------------------------------------------
// nested_interrupt_controller
// Eight-line interrupt controller in fully nested mode.
// ----------------------------------------------------------------------------
// Usage: each request on the s_ channel is one operation (bus write, bus
// read, line request or processor acknowledge). Every request yields exactly
// one result on the m_ channel carrying read data, the acknowledge vector and
// the interrupt output level after that operation.
// Flow: an accepted request waits in the input register and is processed
// into the result register once that register is free or draining.
// Throughput: one request per cycle while m_ready is high; the input and the
// result register let a new request in while a result still waits to be taken.
// Stall: while m_ready is low and a result is held, one further request may
// wait in the input register; s_ready then drops until the result leaves.
// Reset (aresetn low, synchronous): request, in-service and mask bytes clear,
// the interrupt output drops, the read selection is cleared and the vector
// base returns to 8. Both channel registers empty.
// Configuration: cfg_write_en writes the vector base at once; write it only
// while no request is in flight.
// ----------------------------------------------------------------------------
module nested_interrupt_controller #(
    parameter int unsigned LINES = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration
    input  logic                       cfg_write_en,
    input  logic [7:0]                 cfg_write_data,
    // request channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_op,
    input  logic                       s_port_select,
    input  logic [7:0]                 s_write_data,
    input  logic [nic_pkg::LINE_W-1:0] s_irq_line,
    // result channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [7:0]                 m_read_data,
    output logic [7:0]                 m_vector,
    output logic                       m_vector_valid,
    output logic                       m_intr
);

    logic             in_valid_reg;
    nic_pkg::item_t   in_item_reg;
    logic             out_valid_reg;
    nic_pkg::result_t out_res_reg;
    nic_pkg::result_t res;
    logic [7:0]       base_reg;
    logic             advance;

    // advance the held request when the result register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // hold the vector base
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= nic_pkg::BASE_RESET;
        end else if (cfg_write_en) begin
            base_reg <= cfg_write_data;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.op          <= nic_pkg::op_t'(s_op);
            in_item_reg.port_select <= s_port_select;
            in_item_reg.write_data  <= s_write_data;
            in_item_reg.irq_line    <= s_irq_line;
        end
    end

    nic_core #(.LINES(LINES)) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .item        (in_item_reg),
        .vector_base (base_reg),
        .result      (res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_read_data    = out_res_reg.read_data;
    assign m_vector       = out_res_reg.vector;
    assign m_vector_valid = out_res_reg.vector_valid;
    assign m_intr         = out_res_reg.intr;

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Nested interrupt controller testbench
// Drives bus writes, bus reads, line requests and acknowledges into the
// controller with random idling on both channels. A shadow copy of the
// request, in-service and mask bytes predicts every response, and each
// response is checked field by field against the prediction.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NUM_LINES    = 8;   // lines of the instance under test
    localparam int NO_LINE      = NUM_LINES;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 8;   // cycles to wait once nothing is due
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 125;
    localparam int MAX_REPORTS  = 50;

    // ------------------------------------------------------------------------
    // Shadow of the controller state and the queue of responses still due
    // ------------------------------------------------------------------------
    class interrupt_tracker;
        logic [7:0]       base_reg;
        logic [7:0]       pending;
        logic [7:0]       in_service;
        logic [7:0]       masked;
        logic             intr_level;
        nic_pkg::sel_t    read_sel;
        nic_pkg::result_t due_responses[$];
        int unsigned      errors;

        function new();
            base_reg   = nic_pkg::BASE_RESET;
            pending    = '0;
            in_service = '0;
            masked     = '0;
            intr_level = 1'b0;
            read_sel   = nic_pkg::SEL_NONE;
            errors     = 0;
        endfunction

        function void set_base(logic [7:0] value);
            base_reg = value;
        endfunction

        function int outstanding();
            return due_responses.size();
        endfunction

        function int first_bit(logic [7:0] v);
            for (int i = 0; i < NUM_LINES; i++) begin
                if (v[i]) begin
                    return i;
                end
            end
            return NO_LINE;
        endfunction

        // Line that an acknowledge would take now, NO_LINE if none
        function int granted();
            int cand;
            cand = first_bit(pending & ~masked);
            if (cand < first_bit(in_service)) begin
                return cand;
            end
            return NO_LINE;
        endfunction

        function void raise_if_granted();
            if (granted() < NO_LINE) begin
                intr_level = 1'b1;
            end
        endfunction

        function logic [7:0] effective_base();
            if (base_reg > nic_pkg::BASE_MAX) begin
                return nic_pkg::BASE_FALLBACK;
            end
            return base_reg & nic_pkg::BASE_ALIGN;
        endfunction

        // Advance the shadow state by one accepted request and queue its response
        function void take_request(nic_pkg::item_t it);
            nic_pkg::result_t r;
            int               line;
            r = '0;
            case (it.op)
                nic_pkg::OP_WRITE: begin
                    if (it.port_select) begin
                        masked = it.write_data;
                        raise_if_granted();
                    end else if ((it.write_data & nic_pkg::CMD_EOI_MASK)
                                 == nic_pkg::CMD_EOI) begin
                        line = first_bit(in_service);
                        if (line < NO_LINE) begin
                            in_service[line] = 1'b0;
                        end
                        raise_if_granted();
                    end else if (it.write_data == nic_pkg::CMD_READ_IRR) begin
                        read_sel = nic_pkg::SEL_REQ;
                    end else if (it.write_data == nic_pkg::CMD_READ_ISR) begin
                        read_sel = nic_pkg::SEL_SVC;
                    end
                end
                nic_pkg::OP_READ: begin
                    if (it.port_select) begin
                        r.read_data = masked;
                    end else if (read_sel == nic_pkg::SEL_REQ) begin
                        r.read_data = pending;
                        read_sel    = nic_pkg::SEL_NONE;
                    end else if (read_sel == nic_pkg::SEL_SVC) begin
                        r.read_data = in_service;
                        read_sel    = nic_pkg::SEL_NONE;
                    end
                end
                nic_pkg::OP_LINE: begin
                    if (int'(it.irq_line) < NUM_LINES) begin
                        pending[it.irq_line] = 1'b1;
                        raise_if_granted();
                    end
                end
                default: begin
                    line       = granted();
                    intr_level = 1'b0;
                    if (line < NO_LINE) begin
                        pending[line]    = 1'b0;
                        in_service[line] = 1'b1;
                        r.vector         = effective_base() + 8'(line);
                        r.vector_valid   = 1'b1;
                    end
                end
            endcase
            r.intr = intr_level;
            due_responses.push_back(r);
        endfunction

        task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
            if (errors < MAX_REPORTS) begin
                $display("%0t: mismatch on %s, got 0x%02h, want 0x%02h",
                         $time, what, got, want);
            end
            errors++;
        endtask

        // Compare one delivered response with the oldest one due
        task match_response(nic_pkg::result_t got);
            nic_pkg::result_t want;
            if (due_responses.size() == 0) begin
                report_mismatch("unrequested response", got.read_data, 8'h00);
                return;
            end
            want = due_responses.pop_front();
            if (got.read_data !== want.read_data) begin
                report_mismatch("read_data", got.read_data, want.read_data);
            end
            if (got.vector !== want.vector) begin
                report_mismatch("vector", got.vector, want.vector);
            end
            if (got.vector_valid !== want.vector_valid) begin
                report_mismatch("vector_valid", 8'(got.vector_valid), 8'(want.vector_valid));
            end
            if (got.intr !== want.intr) begin
                report_mismatch("intr", 8'(got.intr), 8'(want.intr));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals; every input of the block is known from time zero
    // ------------------------------------------------------------------------
    logic                         aclk           = 1'b0;
    logic                         aresetn        = 1'b0;
    logic                         cfg_write_en   = 1'b0;
    logic [7:0]                   cfg_write_data = '0;
    logic                         s_valid        = 1'b0;
    logic                         s_ready;
    logic [1:0]                   s_op           = '0;
    logic                         s_port_select  = 1'b0;
    logic [7:0]                   s_write_data   = '0;
    logic [nic_pkg::LINE_W-1:0]   s_irq_line     = '0;
    logic                         m_valid;
    logic                         m_ready        = 1'b0;
    logic [7:0]                   m_read_data;
    logic [7:0]                   m_vector;
    logic                         m_vector_valid;
    logic                         m_intr;

    interrupt_tracker pic = new();
    int unsigned      cycle_count = 0;
    bit               steady_flow = 1'b0;  // when set, neither side idles

    nested_interrupt_controller #(
        .LINES(NUM_LINES)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_port_select (s_port_select),
        .s_write_data  (s_write_data),
        .s_irq_line    (s_irq_line),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_data   (m_read_data),
        .m_vector      (m_vector),
        .m_vector_valid(m_vector_valid),
        .m_intr        (m_intr)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Give up on a hung block: a missing response or a stuck handshake ends here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Watch both handshakes. Values read here are the ones the block saw at
    // this edge, since every driver updates through nonblocking assignments.
    // Note the request before checking, so a same-edge response would still
    // find its prediction waiting.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                pic.take_request(nic_pkg::item_t'{nic_pkg::op_t'(s_op), s_port_select,
                                                  s_write_data, s_irq_line});
            end
            if (m_valid && m_ready) begin
                pic.match_response(nic_pkg::result_t'{m_read_data, m_vector,
                                                      m_vector_valid, m_intr});
            end
        end
    end

    function automatic int unsigned draw_wait();
        return steady_flow ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic nic_pkg::item_t make_request(nic_pkg::op_t op, logic port,
                                                    logic [7:0] data,
                                                    logic [nic_pkg::LINE_W-1:0] line);
        nic_pkg::item_t it;
        it.op          = op;
        it.port_select = port;
        it.write_data  = data;
        it.irq_line    = line;
        return it;
    endfunction

    // Mostly well-formed traffic: lines raised, acknowledged and retired by an
    // end of interrupt, with mask changes and register reads mixed in, and a
    // tail of fully random requests as noise.
    function automatic nic_pkg::item_t pick_request();
        nic_pkg::item_t it;
        int unsigned    roll;
        it.op          = nic_pkg::op_t'($urandom_range(0, 3));
        it.port_select = 1'($urandom_range(0, 1));
        it.write_data  = 8'($urandom_range(0, 255));
        roll           = $urandom_range(0, NUM_LINES - 1);
        it.irq_line    = roll[nic_pkg::LINE_W-1:0];
        roll           = $urandom_range(0, 99);
        if (roll < 30) begin
            it.op = nic_pkg::OP_LINE;
        end else if (roll < 52) begin
            it.op = nic_pkg::OP_ACK;
        end else if (roll < 66) begin
            it.op          = nic_pkg::OP_WRITE;
            it.port_select = 1'b0;
            it.write_data  = nic_pkg::CMD_EOI | 8'($urandom_range(0, 7));
        end else if (roll < 74) begin
            // keep masks sparse so that most lines still get through
            it.op          = nic_pkg::OP_WRITE;
            it.port_select = 1'b1;
            it.write_data  = ($urandom_range(0, 9) == 0) ? 8'hFF
                           : 8'($urandom & $urandom & $urandom);
        end else if (roll < 82) begin
            it.op          = nic_pkg::OP_WRITE;
            it.port_select = 1'b0;
            it.write_data  = $urandom_range(0, 1) ? nic_pkg::CMD_READ_IRR
                                                  : nic_pkg::CMD_READ_ISR;
        end else if (roll < 92) begin
            it.op = nic_pkg::OP_READ;
        end
        return it;
    endfunction

    // Offer one request and hold it until accepted. On entry the caller sits
    // at a clock edge; s_valid is only lowered when a gap is drawn, so a
    // back-to-back request never sees valid dropped and raised in one step.
    task automatic send_request(input nic_pkg::item_t it);
        int unsigned gap;
        gap = draw_wait();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_op          <= it.op;
        s_port_select <= it.port_select;
        s_write_data  <= it.write_data;
        s_irq_line    <= it.irq_line;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Take responses forever, stalling for a fresh random spell before each
    task automatic take_responses();
        int unsigned stall;
        @(posedge aclk);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    endtask

    // With valid dropped by the caller, let every due response arrive, then write the vector base.
    // Every request yields a response, so an empty queue means the block idles.
    // Wait for a clock edge first so that the last accepted request is already queued.
    task automatic write_base(input logic [7:0] value);
        @(posedge aclk);
        while (pic.outstanding() != 0) @(posedge aclk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge aclk);
        cfg_write_en   <= 1'b0;
        pic.set_base(value);
    endtask

    initial begin
        take_responses();
    end

    initial begin
        logic [7:0] base;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opening under the reset base of 8
        send_request(make_request(nic_pkg::OP_READ, 1'b1, 8'h00, 3'd0));   // mask reads 0
        send_request(make_request(nic_pkg::OP_READ, 1'b0, 8'h00, 3'd0));   // nothing selected
        send_request(make_request(nic_pkg::OP_WRITE, 1'b0, nic_pkg::CMD_READ_IRR, 3'd0));
        send_request(make_request(nic_pkg::OP_READ, 1'b0, 8'hFF, 3'd7));
        send_request(make_request(nic_pkg::OP_READ, 1'b0, 8'h00, 3'd0));   // selection is one-shot
        send_request(make_request(nic_pkg::OP_ACK, 1'b0, 8'h00, 3'd0));    // empty acknowledge
        send_request(make_request(nic_pkg::OP_LINE, 1'b0, 8'h00, 3'd0));
        send_request(make_request(nic_pkg::OP_LINE, 1'b1, 8'hFF, 3'd7));
        send_request(make_request(nic_pkg::OP_ACK, 1'b1, 8'hFF, 3'd7));    // grants line 0
        send_request(make_request(nic_pkg::OP_ACK, 1'b0, 8'h00, 3'd0));    // line 7 blocked by 0
        send_request(make_request(nic_pkg::OP_WRITE, 1'b0, nic_pkg::CMD_READ_ISR, 3'd0));
        send_request(make_request(nic_pkg::OP_READ, 1'b0, 8'h00, 3'd0));
        send_request(make_request(nic_pkg::OP_WRITE, 1'b0, nic_pkg::CMD_EOI | 8'h07, 3'd0));
        send_request(make_request(nic_pkg::OP_ACK, 1'b0, 8'h00, 3'd0));    // grants line 7
        send_request(make_request(nic_pkg::OP_WRITE, 1'b1, 8'hFF, 3'd0));  // mask every line
        send_request(make_request(nic_pkg::OP_LINE, 1'b0, 8'h00, 3'd3));
        send_request(make_request(nic_pkg::OP_READ, 1'b1, 8'h00, 3'd0));
        send_request(make_request(nic_pkg::OP_WRITE, 1'b1, 8'h00, 3'd0));  // unmask raises intr
        send_request(make_request(nic_pkg::OP_WRITE, 1'b0, 8'h28, 3'd0));  // above EOI range
        send_request(make_request(nic_pkg::OP_WRITE, 1'b0, 8'h1F, 3'd0));  // just below it
        send_request(make_request(nic_pkg::OP_ACK, 1'b0, 8'h00, 3'd0));
        send_request(make_request(nic_pkg::OP_WRITE, 1'b0, nic_pkg::CMD_EOI, 3'd0));
        send_request(make_request(nic_pkg::OP_WRITE, 1'b0, nic_pkg::CMD_EOI, 3'd0));
        send_request(make_request(nic_pkg::OP_WRITE, 1'b0, nic_pkg::CMD_EOI, 3'd0)); // none
        send_request(make_request(nic_pkg::OP_ACK, 1'b0, 8'h00, 3'd0));
        s_valid <= 1'b0;

        // Random phases, each under its own vector base: both ends of the
        // legal range, the out-of-range values that fall back, then random
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       base = 8'h00;
                1:       base = nic_pkg::BASE_MAX;
                2:       base = 8'hFF;
                3:       base = nic_pkg::BASE_MAX + 8'd1;
                default: base = 8'($urandom_range(0, 255));
            endcase
            write_base(base);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold a spell without idling now and then
                if (n % 40 == 0) begin
                    steady_flow = ($urandom_range(0, 3) == 0);
                end
                send_request(pick_request());
            end
            s_valid <= 1'b0;
        end
        steady_flow = 1'b0;

        @(posedge aclk);
        while (pic.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (pic.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
